// File: rtl/c2d_pkg.sv
// ============================================================================
// c2d_pkg: shared definitions for the line-buffer convolution block
// Sizes, field widths, request formats and register codes used by all files.
// ============================================================================
`default_nettype none

package c2d_pkg;

    // Block dimensions.
    localparam int NUM_FILTERS = 4;
    localparam int KERNEL_ROWS = 3;
    localparam int KERNEL_COLS = 3;
    localparam int MAX_LINE    = 32;
    localparam int DATA_BITS   = 16;
    localparam int FRAC_BITS   = 8;

    localparam int TAPS      = KERNEL_ROWS * KERNEL_COLS;
    localparam int STORE_LEN = KERNEL_ROWS * MAX_LINE;

    // Field widths of the request formats.
    localparam int SEL_W  = 2;
    localparam int TAP_W  = 2;
    localparam int ROW_W  = 10;
    localparam int COL_W  = 5;
    localparam int FEAT_W = DATA_BITS - 1;

    // Index width into the per-filter tables.
    localparam int FILTER_IDX_W = (NUM_FILTERS > 1) ? $clog2(NUM_FILTERS) : 1;

    // Configuration registers.
    localparam int COLS_W   = 6;
    localparam int ROWS_W   = 11;
    localparam int ROWS_MAX = 1024;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_COLS = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_ROWS = 1'b1;
    localparam logic [COLS_W-1:0] COLS_RESET = 6'd28;
    localparam logic [ROWS_W-1:0] ROWS_RESET = 11'd28;

    // Datapath widths.
    localparam int PROD_W     = 2 * DATA_BITS;
    localparam int GROUP      = 3;
    localparam int NUM_GROUPS = (TAPS + GROUP - 1) / GROUP;
    localparam int GSUM_W     = PROD_W + $clog2(GROUP + 1);
    localparam int ACC_W      = PROD_W + $clog2(TAPS + 2);

    typedef enum logic [1:0] {
        MODE_PIXEL  = 2'd0,
        MODE_WEIGHT = 2'd1,
        MODE_BIAS   = 2'd2
    } mode_t;

    typedef struct packed {
        mode_t                        mode;
        logic signed [DATA_BITS-1:0]  pixel;
        logic signed [DATA_BITS-1:0]  coef;
        logic [SEL_W-1:0]             filter_sel;
        logic [TAP_W-1:0]             tap_row;
        logic [TAP_W-1:0]             tap_col;
    } in_req_t;

    typedef struct packed {
        logic [SEL_W-1:0]  filter_index;
        logic [ROW_W-1:0]  out_row;
        logic [COL_W-1:0]  out_col;
        logic [FEAT_W-1:0] feature;
        logic              last;
    } out_req_t;

    // Kernel window, tap index = row * KERNEL_COLS + col, row 0 is the oldest line.
    typedef logic [TAPS-1:0][DATA_BITS-1:0] window_t;

    // Control bundle that every tap cell receives.
    typedef struct packed {
        logic                    wr_en;
        logic [FILTER_IDX_W-1:0] wr_filter;
        logic [FILTER_IDX_W-1:0] rd_filter;
        logic                    advance;
    } tap_ctl_t;

endpackage

`default_nettype wire

// File: rtl/c2d_line_buffer.sv
// ============================================================================
// c2d_line_buffer: pixel shift chain with kernel window taps
// A row of pixel cells, each handing its pixel to the next on every new pixel.
// ============================================================================
`default_nettype none

module c2d_line_buffer (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            shift_en,
    input  wire logic [c2d_pkg::DATA_BITS-1:0]   pixel_in,
    input  wire logic [c2d_pkg::COLS_W-1:0]      cols,
    output c2d_pkg::window_t                     window
);

    logic [c2d_pkg::STORE_LEN-1:0][c2d_pkg::DATA_BITS-1:0] cell_reg;
    logic [c2d_pkg::STORE_LEN-1:0][c2d_pkg::DATA_BITS-1:0] cell_next;

    // The newest pixel enters at the top end; every cell takes its upper neighbor.
    always_comb begin
        cell_next = cell_reg;
        if (shift_en) begin
            for (int k = 0; k < c2d_pkg::STORE_LEN - 1; k++) begin
                cell_next[k] = cell_reg[k + 1];
            end
            cell_next[c2d_pkg::STORE_LEN-1] = pixel_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg <= '0;
        end else begin
            cell_reg <= cell_next;
        end
    end

    // Each tap sits a whole number of lines plus a few pixels back from the
    // newest cell; the line length picks one of MAX_LINE cells per tap.
    always_comb begin
        window = '0;
        for (int i = 0; i < c2d_pkg::KERNEL_ROWS; i++) begin
            for (int j = 0; j < c2d_pkg::KERNEL_COLS; j++) begin
                for (int c = 1; c <= c2d_pkg::MAX_LINE; c++) begin
                    if (cols == c2d_pkg::COLS_W'(c)) begin
                        window[i * c2d_pkg::KERNEL_COLS + j] =
                            cell_reg[c2d_pkg::STORE_LEN - 1
                                     - (c2d_pkg::KERNEL_COLS - 1 - j)
                                     - (c2d_pkg::KERNEL_ROWS - 1 - i) * c];
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/c2d_tap_cell.sv
// ============================================================================
// c2d_tap_cell: one kernel tap with its weights for every filter
// Holds one weight per filter and multiplies the window pixel by one of them.
// ============================================================================
`default_nettype none

module c2d_tap_cell (
    input  wire logic                                 aclk,
    input  wire c2d_pkg::tap_ctl_t                    ctl,
    input  wire logic [c2d_pkg::DATA_BITS-1:0]        coef,
    input  wire logic [c2d_pkg::DATA_BITS-1:0]        pixel,
    output logic signed [c2d_pkg::PROD_W-1:0]         product
);

    logic [c2d_pkg::NUM_FILTERS-1:0][c2d_pkg::DATA_BITS-1:0] weight_reg;
    logic [c2d_pkg::NUM_FILTERS-1:0][c2d_pkg::DATA_BITS-1:0] weight_next;
    logic signed [c2d_pkg::PROD_W-1:0]    product_reg;
    logic signed [c2d_pkg::PROD_W-1:0]    product_next;
    logic signed [c2d_pkg::DATA_BITS-1:0] pix_s;
    logic signed [c2d_pkg::DATA_BITS-1:0] wgt_s;

    always_comb begin
        weight_next = weight_reg;
        if (ctl.wr_en) begin
            weight_next[ctl.wr_filter] = coef;
        end
    end

    assign pix_s        = $signed(pixel);
    assign wgt_s        = $signed(weight_reg[ctl.rd_filter]);
    assign product_next = pix_s * wgt_s;

    always_ff @(posedge aclk) begin
        weight_reg <= weight_next;
        if (ctl.advance) begin
            product_reg <= product_next;
        end
    end

    assign product = product_reg;

endmodule

`default_nettype wire

// File: rtl/conv2d_linebuffer_bias_relu_top.sv
// ============================================================================
// conv2d_linebuffer_bias_relu_top: multi-filter 3x3 convolution with bias and ReLU
// Raster pixel stream in, one saturated feature value per filter out.
// ============================================================================
//
//  Channel   Direction  Handshake              Payload
//  s_        in         s_valid / s_ready      c2d_pkg::in_req_t  (pixel or load)
//  m_        out        m_valid / m_ready      c2d_pkg::out_req_t (one feature)
//  APB       in         psel/penable/pready    image_cols at 0x0, image_rows at 0x4
//
//  A pixel whose window lies inside the frame is issued once per filter
//  (NUM_FILTERS, 4 by default) through the nine shared tap multipliers; the next
//  request is taken in the cycle that issues the last filter. Loads and pixels
//  outside the valid window are taken at one per cycle between jobs while the
//  output does not stall. Results pass the product, sum and output registers.
//  Reset is synchronous and active low; it clears the pixel cells and counters.
//  A full output register with m_ready low stalls the whole datapath in place.
//
`default_nettype none

module conv2d_linebuffer_bias_relu_top (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // Input request channel.
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire c2d_pkg::in_req_t                 s_req,
    // Result channel.
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output c2d_pkg::out_req_t                     m_req,
    // Configuration port.
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [c2d_pkg::PADDR_W-1:0]      paddr,
    input  wire logic [c2d_pkg::PDATA_W-1:0]      pwdata,
    output logic [c2d_pkg::PDATA_W-1:0]           prdata,
    output logic                                  pready
);

    // Job information that travels with each issued filter.
    typedef struct packed {
        logic [c2d_pkg::SEL_W-1:0] filter;
        logic [c2d_pkg::ROW_W-1:0] row;
        logic [c2d_pkg::COL_W-1:0] col;
    } meta_t;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [c2d_pkg::COLS_W-1:0]    cols_reg;
    logic [c2d_pkg::COLS_W-1:0]    cols_next;
    logic [c2d_pkg::ROWS_W-1:0]    rows_reg;
    logic [c2d_pkg::ROWS_W-1:0]    rows_next;
    logic [c2d_pkg::REG_IDX_W-1:0] reg_idx;
    logic                          cfg_wr;
    logic [c2d_pkg::COLS_W-1:0]    cols_eff;
    logic [c2d_pkg::ROWS_W-1:0]    rows_eff;

    assign pready  = 1'b1;
    assign reg_idx = paddr[c2d_pkg::PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        cols_next = cols_reg;
        rows_next = rows_reg;
        if (cfg_wr) begin
            case (reg_idx)
                c2d_pkg::REG_IMAGE_COLS: begin
                    cols_next = pwdata[c2d_pkg::COLS_W-1:0];
                end
                c2d_pkg::REG_IMAGE_ROWS: begin
                    rows_next = pwdata[c2d_pkg::ROWS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            c2d_pkg::REG_IMAGE_COLS: begin
                prdata = c2d_pkg::PDATA_W'(cols_reg);
            end
            c2d_pkg::REG_IMAGE_ROWS: begin
                prdata = c2d_pkg::PDATA_W'(rows_reg);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg <= c2d_pkg::COLS_RESET;
            rows_reg <= c2d_pkg::ROWS_RESET;
        end else begin
            cols_reg <= cols_next;
            rows_reg <= rows_next;
        end
    end

    // The dimensions in use are clamped to 1..MAX_LINE and 1..ROWS_MAX.
    always_comb begin
        if (cols_reg == '0) begin
            cols_eff = c2d_pkg::COLS_W'(1);
        end else if (cols_reg > c2d_pkg::COLS_W'(c2d_pkg::MAX_LINE)) begin
            cols_eff = c2d_pkg::COLS_W'(c2d_pkg::MAX_LINE);
        end else begin
            cols_eff = cols_reg;
        end
        if (rows_reg == '0) begin
            rows_eff = c2d_pkg::ROWS_W'(1);
        end else if (rows_reg > c2d_pkg::ROWS_W'(c2d_pkg::ROWS_MAX)) begin
            rows_eff = c2d_pkg::ROWS_W'(c2d_pkg::ROWS_MAX);
        end else begin
            rows_eff = rows_reg;
        end
    end

    // ------------------------------------------------------------------
    // Input handshake and filter sequencer.
    // ------------------------------------------------------------------
    // The whole datapath moves only when the output register can take a value.
    logic advance;
    logic seq_active_reg;
    logic seq_active_next;
    logic [c2d_pkg::SEL_W-1:0] seq_filter_reg;
    logic [c2d_pkg::SEL_W-1:0] seq_filter_next;
    logic [c2d_pkg::ROW_W-1:0] job_row_reg;
    logic [c2d_pkg::ROW_W-1:0] job_row_next;
    logic [c2d_pkg::COL_W-1:0] job_col_reg;
    logic [c2d_pkg::COL_W-1:0] job_col_next;
    logic seq_last;
    logic issue;
    logic s_fire;
    logic pix_fire;
    logic win_hit;

    assign advance  = !m_valid || m_ready;
    assign seq_last = (seq_filter_reg == c2d_pkg::SEL_W'(c2d_pkg::NUM_FILTERS - 1));
    assign issue    = seq_active_reg && advance;

    // A new request may enter while the last filter of the current pixel issues;
    // the window and the weight tables are no longer needed after that cycle.
    assign s_ready  = advance && (!seq_active_reg || seq_last);
    assign s_fire   = s_valid && s_ready;
    assign pix_fire = s_fire && (s_req.mode == c2d_pkg::MODE_PIXEL);

    // Row and column counters of the pixel being accepted.
    logic [c2d_pkg::ROW_W-1:0] row_count_reg;
    logic [c2d_pkg::ROW_W-1:0] row_count_next;
    logic [c2d_pkg::COL_W-1:0] col_count_reg;
    logic [c2d_pkg::COL_W-1:0] col_count_next;
    logic [c2d_pkg::COLS_W-1:0] col_inc;
    logic [c2d_pkg::ROWS_W-1:0] row_inc;

    assign win_hit = (row_count_reg >= c2d_pkg::ROW_W'(c2d_pkg::KERNEL_ROWS - 1))
                  && (col_count_reg >= c2d_pkg::COL_W'(c2d_pkg::KERNEL_COLS - 1));
    assign col_inc = c2d_pkg::COLS_W'(col_count_reg) + c2d_pkg::COLS_W'(1);
    assign row_inc = c2d_pkg::ROWS_W'(row_count_reg) + c2d_pkg::ROWS_W'(1);

    // A counter that sits past a smaller new limit wraps on its next step.
    always_comb begin
        row_count_next = row_count_reg;
        col_count_next = col_count_reg;
        if (pix_fire) begin
            if (col_inc >= cols_eff) begin
                col_count_next = '0;
                if (row_inc >= rows_eff) begin
                    row_count_next = '0;
                end else begin
                    row_count_next = row_inc[c2d_pkg::ROW_W-1:0];
                end
            end else begin
                col_count_next = col_inc[c2d_pkg::COL_W-1:0];
            end
        end
    end

    always_comb begin
        seq_active_next = seq_active_reg;
        seq_filter_next = seq_filter_reg;
        job_row_next    = job_row_reg;
        job_col_next    = job_col_reg;
        if (issue) begin
            if (seq_last) begin
                seq_active_next = 1'b0;
            end else begin
                seq_filter_next = seq_filter_reg + c2d_pkg::SEL_W'(1);
            end
        end
        if (pix_fire && win_hit) begin
            seq_active_next = 1'b1;
            seq_filter_next = '0;
            job_row_next    = row_count_reg - c2d_pkg::ROW_W'(c2d_pkg::KERNEL_ROWS - 1);
            job_col_next    = col_count_reg - c2d_pkg::COL_W'(c2d_pkg::KERNEL_COLS - 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_active_reg <= 1'b0;
            seq_filter_reg <= '0;
            row_count_reg  <= '0;
            col_count_reg  <= '0;
        end else begin
            seq_active_reg <= seq_active_next;
            seq_filter_reg <= seq_filter_next;
            row_count_reg  <= row_count_next;
            col_count_reg  <= col_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_row_reg <= job_row_next;
        job_col_reg <= job_col_next;
    end

    // ------------------------------------------------------------------
    // Line buffer: the pixel cells shift once per accepted pixel.
    // ------------------------------------------------------------------
    c2d_pkg::window_t window;

    c2d_line_buffer u_line_buffer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .shift_en (pix_fire),
        .pixel_in (s_req.pixel),
        .cols     (cols_eff),
        .window   (window)
    );

    // ------------------------------------------------------------------
    // Tap cells: weight loads and the first pipeline stage (products).
    // ------------------------------------------------------------------
    logic wgt_wr;
    logic [c2d_pkg::TAPS-1:0][c2d_pkg::PROD_W-1:0] product_bus;

    // Loads outside the kernel or beyond the filter count are dropped.
    assign wgt_wr = s_fire && (s_req.mode == c2d_pkg::MODE_WEIGHT)
                 && (int'(s_req.filter_sel) < c2d_pkg::NUM_FILTERS)
                 && (int'(s_req.tap_row) < c2d_pkg::KERNEL_ROWS)
                 && (int'(s_req.tap_col) < c2d_pkg::KERNEL_COLS);

    for (genvar r = 0; r < c2d_pkg::KERNEL_ROWS; r++) begin : g_row
        for (genvar c = 0; c < c2d_pkg::KERNEL_COLS; c++) begin : g_col
            c2d_pkg::tap_ctl_t ctl;
            logic signed [c2d_pkg::PROD_W-1:0] product;

            assign ctl.wr_en     = wgt_wr && (s_req.tap_row == c2d_pkg::TAP_W'(r))
                                          && (s_req.tap_col == c2d_pkg::TAP_W'(c));
            assign ctl.wr_filter = s_req.filter_sel[c2d_pkg::FILTER_IDX_W-1:0];
            assign ctl.rd_filter = seq_filter_reg[c2d_pkg::FILTER_IDX_W-1:0];
            assign ctl.advance   = advance;

            c2d_tap_cell u_tap (
                .aclk    (aclk),
                .ctl     (ctl),
                .coef    (s_req.coef),
                .pixel   (window[r * c2d_pkg::KERNEL_COLS + c]),
                .product (product)
            );

            assign product_bus[r * c2d_pkg::KERNEL_COLS + c] = product;
        end
    end

    // Bias table, one entry per filter.
    logic [c2d_pkg::NUM_FILTERS-1:0][c2d_pkg::DATA_BITS-1:0] bias_reg;
    logic [c2d_pkg::NUM_FILTERS-1:0][c2d_pkg::DATA_BITS-1:0] bias_next;

    always_comb begin
        bias_next = bias_reg;
        if (s_fire && (s_req.mode == c2d_pkg::MODE_BIAS)
                && (int'(s_req.filter_sel) < c2d_pkg::NUM_FILTERS)) begin
            bias_next[s_req.filter_sel[c2d_pkg::FILTER_IDX_W-1:0]] = s_req.coef;
        end
    end

    always_ff @(posedge aclk) begin
        bias_reg <= bias_next;
    end

    // Stage 1 side registers, alongside the products held in the tap cells.
    logic  s1_valid_reg;
    meta_t s1_meta_reg;
    logic [c2d_pkg::DATA_BITS-1:0] s1_bias_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_meta_reg <= '{filter: seq_filter_reg, row: job_row_reg, col: job_col_reg};
            s1_bias_reg <= bias_reg[seq_filter_reg[c2d_pkg::FILTER_IDX_W-1:0]];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: products are summed in small groups.
    // ------------------------------------------------------------------
    logic  s2_valid_reg;
    meta_t s2_meta_reg;
    logic [c2d_pkg::DATA_BITS-1:0] s2_bias_reg;
    logic signed [c2d_pkg::GSUM_W-1:0] gsum_reg  [c2d_pkg::NUM_GROUPS];
    logic signed [c2d_pkg::GSUM_W-1:0] gsum_next [c2d_pkg::NUM_GROUPS];

    always_comb begin
        for (int g = 0; g < c2d_pkg::NUM_GROUPS; g++) begin
            gsum_next[g] = '0;
            for (int k = 0; k < c2d_pkg::GROUP; k++) begin
                if (g * c2d_pkg::GROUP + k < c2d_pkg::TAPS) begin
                    gsum_next[g] = gsum_next[g] + c2d_pkg::GSUM_W'(
                        $signed(product_bus[g * c2d_pkg::GROUP + k]));
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (advance) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s2_meta_reg <= s1_meta_reg;
            s2_bias_reg <= s1_bias_reg;
            gsum_reg    <= gsum_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: total plus bias, floor to Q8.8, ReLU and saturation.
    // ------------------------------------------------------------------
    localparam logic signed [c2d_pkg::ACC_W-1:0] FEAT_MAX =
        c2d_pkg::ACC_W'((64'sd1 <<< (c2d_pkg::DATA_BITS - 1)) - 64'sd1);

    logic signed [c2d_pkg::ACC_W-1:0] acc_total;
    logic signed [c2d_pkg::ACC_W-1:0] acc_shift;
    logic [c2d_pkg::FEAT_W-1:0]       feat_sat;
    logic                             m_valid_reg;
    c2d_pkg::out_req_t                m_req_reg;
    c2d_pkg::out_req_t                m_req_next;

    always_comb begin
        acc_total = c2d_pkg::ACC_W'($signed(s2_bias_reg)) <<< c2d_pkg::FRAC_BITS;
        for (int g = 0; g < c2d_pkg::NUM_GROUPS; g++) begin
            acc_total = acc_total + c2d_pkg::ACC_W'(gsum_reg[g]);
        end
        acc_shift = acc_total >>> c2d_pkg::FRAC_BITS;
        if (acc_shift < 0) begin
            feat_sat = '0;
        end else if (acc_shift > FEAT_MAX) begin
            feat_sat = FEAT_MAX[c2d_pkg::FEAT_W-1:0];
        end else begin
            feat_sat = acc_shift[c2d_pkg::FEAT_W-1:0];
        end
    end

    always_comb begin
        m_req_next.filter_index = s2_meta_reg.filter;
        m_req_next.out_row      = s2_meta_reg.row;
        m_req_next.out_col      = s2_meta_reg.col;
        m_req_next.feature      = feat_sat;
        m_req_next.last         =
            (s2_meta_reg.filter == c2d_pkg::SEL_W'(c2d_pkg::NUM_FILTERS - 1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_req_reg <= m_req_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_req   = m_req_reg;

`ifndef SYNTHESIS
    // No request is taken while the sequencer still has filters to issue.
    a_no_accept_midjob: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> (!seq_active_reg || seq_last))
        else $error("request accepted while filters of the previous pixel remain");

    // A pixel inside the frame starts a job at the first filter.
    a_job_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (pix_fire && win_hit) |=> (seq_active_reg && seq_filter_reg == '0))
        else $error("in-window pixel did not start the filter sequence");

    // A stalled output freezes the sequencer.
    a_seq_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (seq_active_reg && !advance) |=> (seq_active_reg && $stable(seq_filter_reg)))
        else $error("sequencer moved during an output stall");

    // The last flag marks exactly the final filter of a pixel.
    a_last_filter: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_req.last ==
            (m_req.filter_index == c2d_pkg::SEL_W'(c2d_pkg::NUM_FILTERS - 1))))
        else $error("last flag does not match the final filter");
`endif

endmodule

`default_nettype wire

// File: sim/conv2d_linebuffer_bias_relu_top_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// conv2d_linebuffer_bias_relu_top_tb: self-checking bench for the 3x3 filter bank
// Streams pixel and coefficient requests through the valid/ready input under
// random stalls on both channels and predicts every feature result in-bench.
// Image sizes change over APB between phases, including clamped and mid-frame
// settings. One long output hold-off backs the pipeline up into the input.
// ============================================================================

module conv2d_linebuffer_bias_relu_top_tb;

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 11;
    // Margin for results still leaving the pipe after issue; it also covers loads
    // and pixels outside the window that are still in the pipe.
    localparam int DRAIN_CYCLES   = 16;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;

    // The mode encoding left unused by the block; requests carrying it are dropped.
    localparam c2d_pkg::mode_t MODE_UNUSED = c2d_pkg::mode_t'(2'd3);

    localparam logic [c2d_pkg::DATA_BITS-1:0] Q_MAX =
        {1'b0, {(c2d_pkg::DATA_BITS-1){1'b1}}};
    localparam logic [c2d_pkg::DATA_BITS-1:0] Q_MIN =
        {1'b1, {(c2d_pkg::DATA_BITS-1){1'b0}}};
    localparam logic [c2d_pkg::DATA_BITS-1:0] Q_ONE =
        c2d_pkg::DATA_BITS'(1) << c2d_pkg::FRAC_BITS;

    // ------------------------------------------------------------------------
    // Block ports. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                          aclk    = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    c2d_pkg::in_req_t              s_req   = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    c2d_pkg::out_req_t             m_req;
    logic                          psel    = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite  = 1'b0;
    logic [c2d_pkg::PADDR_W-1:0]   paddr   = '0;
    logic [c2d_pkg::PDATA_W-1:0]   pwdata  = '0;
    logic [c2d_pkg::PDATA_W-1:0]   prdata;
    logic                          pready;

    conv2d_linebuffer_bias_relu_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_req   (m_req),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------------
    // Bench state. The initial block fills request_backlog; the driver empties
    // it. Each accepted pixel pushes its feature results onto
    // expected_features, which the monitor consumes in order.
    // ------------------------------------------------------------------------
    c2d_pkg::in_req_t  request_backlog[$];
    c2d_pkg::out_req_t expected_features[$];

    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    bit hold_armed      = 1'b0;
    bit hold_done       = 1'b0;
    int hold_left       = 0;
    int quiet_cycles    = 0;
    int fail_count      = 0;
    int pixel_reqs      = 0;
    int load_reqs       = 0;
    int ignored_reqs    = 0;
    int results_checked = 0;

    // Shadow copy of the block: line store, coefficient tables, raster
    // position and the raw dimension registers.
    logic signed [c2d_pkg::DATA_BITS-1:0] px_line [c2d_pkg::STORE_LEN];
    logic signed [c2d_pkg::DATA_BITS-1:0] kern_w  [c2d_pkg::NUM_FILTERS][c2d_pkg::TAPS];
    logic signed [c2d_pkg::DATA_BITS-1:0] kern_b  [c2d_pkg::NUM_FILTERS];
    int unsigned                          row_pos  = 0;
    int unsigned                          col_pos  = 0;
    logic [c2d_pkg::COLS_W-1:0]           dim_cols = c2d_pkg::COLS_RESET;
    logic [c2d_pkg::ROWS_W-1:0]           dim_rows = c2d_pkg::ROWS_RESET;

    initial begin
        forever #HALF_PERIOD aclk = ~aclk;
    end

    // Applies one accepted request to the shadow state. A pixel whose 3x3
    // window lies inside the frame yields one result per filter: the dot
    // product at full precision plus the bias, floored to Q8.8, then clipped
    // to the range [0, Q_MAX].
    task automatic convolve_request(input c2d_pkg::in_req_t req);
        int unsigned       ncols;
        int unsigned       nrows;
        int unsigned       tap_dist;
        longint            acc;
        longint            v;
        c2d_pkg::out_req_t res;
        begin
            case (req.mode)
                c2d_pkg::MODE_WEIGHT: begin
                    if (req.filter_sel < c2d_pkg::NUM_FILTERS &&
                        req.tap_row < c2d_pkg::KERNEL_ROWS &&
                        req.tap_col < c2d_pkg::KERNEL_COLS) begin
                        kern_w[req.filter_sel]
                              [req.tap_row * c2d_pkg::KERNEL_COLS + req.tap_col] = req.coef;
                        load_reqs++;
                    end else begin
                        ignored_reqs++;
                    end
                end
                c2d_pkg::MODE_BIAS: begin
                    if (req.filter_sel < c2d_pkg::NUM_FILTERS) begin
                        kern_b[req.filter_sel] = req.coef;
                        load_reqs++;
                    end else begin
                        ignored_reqs++;
                    end
                end
                c2d_pkg::MODE_PIXEL: begin
                    pixel_reqs++;
                    // Out-of-range dimensions are clamped, zero meaning one.
                    ncols = (dim_cols == 0) ? 1 :
                            (dim_cols > c2d_pkg::MAX_LINE ? c2d_pkg::MAX_LINE : dim_cols);
                    nrows = (dim_rows == 0) ? 1 :
                            (dim_rows > c2d_pkg::ROWS_MAX ? c2d_pkg::ROWS_MAX : dim_rows);
                    for (int k = 0; k < c2d_pkg::STORE_LEN - 1; k++) begin
                        px_line[k] = px_line[k + 1];
                    end
                    px_line[c2d_pkg::STORE_LEN - 1] = req.pixel;
                    if (row_pos >= c2d_pkg::KERNEL_ROWS - 1 &&
                        col_pos >= c2d_pkg::KERNEL_COLS - 1) begin
                        for (int f = 0; f < c2d_pkg::NUM_FILTERS; f++) begin
                            acc = 0;
                            for (int i = 0; i < c2d_pkg::KERNEL_ROWS; i++) begin
                                for (int j = 0; j < c2d_pkg::KERNEL_COLS; j++) begin
                                    tap_dist = (c2d_pkg::KERNEL_ROWS - 1 - i) * ncols
                                             + (c2d_pkg::KERNEL_COLS - 1 - j);
                                    acc += longint'(px_line[c2d_pkg::STORE_LEN - 1 - tap_dist])
                                         * longint'(kern_w[f][i * c2d_pkg::KERNEL_COLS + j]);
                                end
                            end
                            acc += longint'(kern_b[f]) <<< c2d_pkg::FRAC_BITS;
                            v = acc >>> c2d_pkg::FRAC_BITS;
                            if (v < 0) begin
                                v = 0;
                            end
                            if (v > longint'(Q_MAX)) begin
                                v = longint'(Q_MAX);
                            end
                            res.filter_index = c2d_pkg::SEL_W'(f);
                            res.out_row      =
                                c2d_pkg::ROW_W'(row_pos - (c2d_pkg::KERNEL_ROWS - 1));
                            res.out_col      =
                                c2d_pkg::COL_W'(col_pos - (c2d_pkg::KERNEL_COLS - 1));
                            res.feature      = v[c2d_pkg::FEAT_W-1:0];
                            res.last         = (f == c2d_pkg::NUM_FILTERS - 1);
                            expected_features.push_back(res);
                        end
                    end
                    // Counters are never cleared by a size change; one already
                    // past a smaller limit wraps on its next step.
                    if (col_pos + 1 >= ncols) begin
                        col_pos = 0;
                        row_pos = (row_pos + 1 >= nrows) ? 0 : row_pos + 1;
                    end else begin
                        col_pos = col_pos + 1;
                    end
                end
                default: begin
                    ignored_reqs++;
                end
            endcase
        end
    endtask

    // Mix of full-range, near-zero and saturating Q8.8 values.
    function automatic logic [c2d_pkg::DATA_BITS-1:0] pick_value();
        logic [c2d_pkg::DATA_BITS-1:0] v;
        begin
            case ($urandom_range(3))
                0: v = c2d_pkg::DATA_BITS'($urandom);
                1: v = c2d_pkg::DATA_BITS'($urandom_range(511) - 256);
                2: v = $urandom_range(1) ? Q_MAX : Q_MIN;
                default: v = c2d_pkg::DATA_BITS'($urandom_range(1023));
            endcase
            return v;
        end
    endfunction

    task automatic queue_request(input c2d_pkg::mode_t mode,
                                 input logic [c2d_pkg::DATA_BITS-1:0] pix,
                                 input logic [c2d_pkg::DATA_BITS-1:0] coef, input int fsel,
                                 input int trow, input int tcol);
        c2d_pkg::in_req_t req;
        begin
            req.mode       = mode;
            req.pixel      = pix;
            req.coef       = coef;
            req.filter_sel = c2d_pkg::SEL_W'(fsel);
            req.tap_row    = c2d_pkg::TAP_W'(trow);
            req.tap_col    = c2d_pkg::TAP_W'(tcol);
            request_backlog.push_back(req);
        end
    endtask

    // One APB transfer: setup cycle, then access until pready.
    task automatic apb_access(input logic wr, input logic [c2d_pkg::REG_IDX_W-1:0] idx,
                              input logic [c2d_pkg::PDATA_W-1:0] wdata,
                              output logic [c2d_pkg::PDATA_W-1:0] rdata);
        begin
            @(posedge aclk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= wr;
            paddr   <= {idx, 2'b00};
            pwdata  <= wdata;
            @(posedge aclk);
            penable <= 1'b1;
            do @(posedge aclk); while (!pready);
            rdata = prdata;
            psel    <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    task automatic check_register(input logic [c2d_pkg::REG_IDX_W-1:0] idx,
                                  input logic [c2d_pkg::PDATA_W-1:0] want);
        logic [c2d_pkg::PDATA_W-1:0] got;
        begin
            apb_access(1'b0, idx, '0, got);
            if (got !== want) begin
                $error("prdata at register %0d: expected %0d, got %0d", idx, want, got);
                fail_count++;
            end
        end
    endtask

    // Writes both dimension registers with random bits above each field, so
    // the masking is exercised too, and reads them back.
    task automatic set_dims(input logic [c2d_pkg::COLS_W-1:0] cols,
                            input logic [c2d_pkg::ROWS_W-1:0] rows);
        logic [c2d_pkg::PDATA_W-1:0] junk;
        logic [c2d_pkg::PDATA_W-1:0] unused;
        begin
            junk = $urandom;
            apb_access(1'b1, c2d_pkg::REG_IMAGE_COLS,
                       {junk[c2d_pkg::PDATA_W-1:c2d_pkg::COLS_W], cols}, unused);
            junk = $urandom;
            apb_access(1'b1, c2d_pkg::REG_IMAGE_ROWS,
                       {junk[c2d_pkg::PDATA_W-1:c2d_pkg::ROWS_W], rows}, unused);
            dim_cols = cols;
            dim_rows = rows;
            check_register(c2d_pkg::REG_IMAGE_COLS, c2d_pkg::PDATA_W'(cols));
            check_register(c2d_pkg::REG_IMAGE_ROWS, c2d_pkg::PDATA_W'(rows));
        end
    endtask

    // Returns once every queued request is taken, every predicted result has
    // come back, and the pipe has had time to settle.
    task automatic drain_block();
        begin
            do @(negedge aclk);
            while (request_backlog.size() != 0 || s_valid || expected_features.size() != 0);
            repeat (DRAIN_CYCLES) @(negedge aclk);
        end
    endtask

    // One random phase: new image size, new stall mix, then a stream of
    // requests. Most are pixels so windows keep forming; the rest reload
    // coefficients or are noise the block must drop. Dropped requests do not
    // count toward n_items.
    task automatic run_phase(input logic [c2d_pkg::COLS_W-1:0] cols,
                             input logic [c2d_pkg::ROWS_W-1:0] rows,
                             input int n_items, input int send_pct, input int recv_pct,
                             input bit hold);
        c2d_pkg::in_req_t req;
        int               kind;
        int               made;
        begin
            set_dims(cols, rows);
            send_idle_pct = send_pct;
            recv_idle_pct = recv_pct;
            hold_armed    = hold;
            made = 0;
            while (made < n_items) begin
                req.pixel      = pick_value();
                req.coef       = pick_value();
                req.filter_sel = c2d_pkg::SEL_W'($urandom_range(c2d_pkg::NUM_FILTERS - 1));
                req.tap_row    = c2d_pkg::TAP_W'($urandom_range(c2d_pkg::KERNEL_ROWS - 1));
                req.tap_col    = c2d_pkg::TAP_W'($urandom_range(c2d_pkg::KERNEL_COLS - 1));
                kind = $urandom_range(99);
                if (kind < 76) begin
                    req.mode = c2d_pkg::MODE_PIXEL;
                end else if (kind < 86) begin
                    req.mode = c2d_pkg::MODE_WEIGHT;
                end else if (kind < 92) begin
                    req.mode = c2d_pkg::MODE_BIAS;
                end else if (kind < 96) begin
                    req.mode = MODE_UNUSED;
                end else begin
                    // Weight load aimed outside the kernel.
                    req.mode = c2d_pkg::MODE_WEIGHT;
                    if ($urandom_range(1)) begin
                        req.tap_row = c2d_pkg::TAP_W'(c2d_pkg::KERNEL_ROWS);
                    end else begin
                        req.tap_col = c2d_pkg::TAP_W'(c2d_pkg::KERNEL_COLS);
                    end
                end
                if (req.mode == c2d_pkg::MODE_PIXEL || req.mode == c2d_pkg::MODE_BIAS ||
                    (req.mode == c2d_pkg::MODE_WEIGHT && req.tap_row < c2d_pkg::KERNEL_ROWS &&
                     req.tap_col < c2d_pkg::KERNEL_COLS)) begin
                    made++;
                end
                request_backlog.push_back(req);
            end
            drain_block();
        end
    endtask

    // ------------------------------------------------------------------------
    // Request driver. A request stays on the bus, unchanged, until taken; the
    // prediction is made at the edge where it is taken.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                convolve_request(s_req);
            end
            if (!s_valid || s_ready) begin
                if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_req   <= request_backlog.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor. Each result is matched field by field against the oldest
    // prediction. Once armed, the receiver holds m_ready low through one hold-off
    // so the output register fills and the block has to stall its input.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        c2d_pkg::out_req_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_checked++;
                if (expected_features.size() == 0) begin
                    $error("result with nothing predicted: filter %0d row %0d col %0d",
                           m_req.filter_index, m_req.out_row, m_req.out_col);
                    fail_count++;
                end else begin
                    want = expected_features.pop_front();
                    if (m_req.filter_index !== want.filter_index) begin
                        $error("filter_index: expected %0d, got %0d",
                               want.filter_index, m_req.filter_index);
                        fail_count++;
                    end
                    if (m_req.out_row !== want.out_row) begin
                        $error("out_row: expected %0d, got %0d", want.out_row, m_req.out_row);
                        fail_count++;
                    end
                    if (m_req.out_col !== want.out_col) begin
                        $error("out_col: expected %0d, got %0d", want.out_col, m_req.out_col);
                        fail_count++;
                    end
                    if (m_req.feature !== want.feature) begin
                        $error("feature: expected %0d, got %0d", want.feature, m_req.feature);
                        fail_count++;
                    end
                    if (m_req.last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, m_req.last);
                        fail_count++;
                    end
                end
            end
            if (hold_armed && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: ends the run when no transfer of any kind happens for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable && pready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                         quiet_cycles, expected_features.size());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin
        logic [c2d_pkg::DATA_BITS-1:0] corner_px [15];
        logic [c2d_pkg::DATA_BITS-1:0] w;

        foreach (px_line[k]) begin
            px_line[k] = '0;
        end
        corner_px = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'h0100,
                      16'h0001, 16'h00ff, 16'h7f00, 16'h8001, 16'hff00,
                      16'h0080, 16'h4000, 16'hc000, 16'h1234, 16'hedcc};

        // Reset is held once, at the start, and never again.
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // The dimension registers must come out of reset at their defaults.
        check_register(c2d_pkg::REG_IMAGE_COLS, c2d_pkg::PDATA_W'(c2d_pkg::COLS_RESET));
        check_register(c2d_pkg::REG_IMAGE_ROWS, c2d_pkg::PDATA_W'(c2d_pkg::ROWS_RESET));

        // Directed part: sender idles 30% and receiver 58% of cycles, on the
        // narrowest line that fits the kernel, so windows form every third pixel.
        send_idle_pct = 30;
        recv_idle_pct = 58;
        set_dims(c2d_pkg::COLS_W'(3), c2d_pkg::ROWS_W'(5));

        // Every coefficient is written before any window can form. Filter 0
        // drives toward positive saturation, filter 1 toward zero through the
        // ReLU, filter 2 passes the center tap through unchanged and filter 3
        // gets mixed values with the most negative bias.
        for (int f = 0; f < c2d_pkg::NUM_FILTERS; f++) begin
            for (int t = 0; t < c2d_pkg::TAPS; t++) begin
                case (f)
                    0: w = Q_MAX;
                    1: w = Q_MIN;
                    2: w = (t == c2d_pkg::TAPS / 2) ? Q_ONE : '0;
                    default: w = pick_value();
                endcase
                queue_request(c2d_pkg::MODE_WEIGHT, pick_value(), w, f,
                              t / c2d_pkg::KERNEL_COLS, t % c2d_pkg::KERNEL_COLS);
            end
        end
        queue_request(c2d_pkg::MODE_BIAS, pick_value(), Q_MAX, 0, 0, 0);
        queue_request(c2d_pkg::MODE_BIAS, pick_value(), '0, 1, 1, 1);
        queue_request(c2d_pkg::MODE_BIAS, pick_value(), '0, 2, 2, 2);
        queue_request(c2d_pkg::MODE_BIAS, pick_value(), Q_MIN, 3, 0, 2);

        // Requests the block must drop: the unused mode and weight loads that
        // point outside the kernel in either direction.
        queue_request(MODE_UNUSED, pick_value(), pick_value(), 3, 3, 3);
        queue_request(c2d_pkg::MODE_WEIGHT, pick_value(), pick_value(), 1,
                      c2d_pkg::KERNEL_ROWS, 0);
        queue_request(c2d_pkg::MODE_WEIGHT, pick_value(), pick_value(), 2,
                      0, c2d_pkg::KERNEL_COLS);

        // Five lines of three pixels with extreme and boundary values; the last
        // three lines each complete one window.
        foreach (corner_px[k]) begin
            queue_request(c2d_pkg::MODE_PIXEL, corner_px[k], pick_value(), $urandom_range(3),
                          $urandom_range(3), $urandom_range(3));
        end
        drain_block();

        // Random phases. The raster position carries over every size change, so
        // later phases begin mid-frame. Widths and heights span the legal
        // extremes and values the block has to clamp, zero among them.
        run_phase(c2d_pkg::COLS_W'(32), c2d_pkg::ROWS_W'(3), 36, 30, 58, 1'b0);
        run_phase(c2d_pkg::COLS_W'(63), c2d_pkg::ROWS_W'(2047), 36, 58, 30, 1'b0);
        run_phase(c2d_pkg::COLS_W'(4), c2d_pkg::ROWS_W'(6), 32, 58, 30, 1'b0);
        run_phase(c2d_pkg::COLS_W'(0), c2d_pkg::ROWS_W'(0), 10, 0, 0, 1'b0);
        run_phase(c2d_pkg::COLS_W'(9), c2d_pkg::ROWS_W'(1024), 40, 0, 0, 1'b1);

        $display("Covered %0d pixels, %0d coefficient loads and %0d dropped requests",
                 pixel_reqs, load_reqs, ignored_reqs);
        $display("Checked %0d feature results over six image sizes with %0d mismatches",
                 results_checked, fail_count);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
